FILE: src/packet_time_and_deadtime_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// packet time and deadtime tracker - assertion macros
// ----------------------------------------------------------------------------
`ifndef PACKET_TIME_AND_DEADTIME_TRACKER_CORE_DEFINES_SVH
`define PACKET_TIME_AND_DEADTIME_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PTDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PTDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ptdt_pkg.sv
// ----------------------------------------------------------------------------
// ptdt_pkg
// Types and constants shared by the packet time and deadtime tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdt_pkg;

  // grade codes
  localparam logic [1:0] BAD_GOOD    = 2'd0;
  localparam logic [1:0] BAD_CRC     = 2'd1;
  localparam logic [1:0] BAD_INVALID = 2'd2;
  localparam logic [1:0] BAD_SHORT   = 2'd3;

  // length limits
  localparam logic [11:0] MIN_LEN         = 12'd4;
  localparam logic [11:0] TRIG_MIN_LEN    = 12'd50;
  localparam logic [11:0] MOD_MIN_LEN     = 12'd28;
  localparam logic [11:0] MOD_TINY_LEN    = 12'd8;
  localparam logic [11:0] MOD_PED_MIN_LEN = 12'd122;

  // mode codes
  localparam logic [15:0] TRIG_PED_MODE = 16'h00F0;
  localparam logic [15:0] MOD_PED_MODE  = 16'd2;
  localparam logic [15:0] MOD_RAW_MODE  = 16'd0;
  localparam logic [15:0] MOD_TINY_MODE = 16'd4;

  // module timestamp wrap span, 2^24
  localparam logic [31:0] MOD_SPAN = 32'h0100_0000;

  // dead difference of zero counts as a full 16-bit lap
  localparam logic [16:0] DEAD_LAP = 17'h1_0000;

  // ratio divider: 17-bit dead difference shifted by 16 fraction bits
  localparam int DIV_STEPS = 33;

  // configuration register indexes
  localparam logic CFG_TRIG_LIMIT = 1'b0;
  localparam logic CFG_MOD_LIMIT  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  module_number;
    logic [11:0] packet_length;
    logic [15:0] packet_mode;
    logic        packet_valid;
    logic        crc_ok;
    logic [31:0] time_stamp;
    logic [15:0] dead_count;
  } in_t;

  typedef struct packed {
    logic        trigger_flag;
    logic [4:0]  channel;
    logic        pedestal_stream;
    logic [1:0]  bad_code;
    logic [1:0]  prior_bad_code;
    logic [31:0] sequence_number;
    logic [31:0] wrap_period;
    logic [31:0] tick_gap;
    logic [31:0] dead_frac;
    logic [15:0] mode_out;
  } out_t;

  // per-channel record
  typedef struct packed {
    logic        first;
    logic [31:0] stamp;
    logic [31:0] period;
    logic [15:0] dead;
    logic [31:0] good;
    logic [1:0]  bad;
  } chan_rec_t;

  localparam chan_rec_t REC_RESET = '{first: 1'b1, stamp: 32'd0, period: 32'd0,
                                      dead: 16'd0, good: 32'd0, bad: BAD_GOOD};

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic mem_rd;
    logic calc;
    logic div_start;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic need_div;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

FILE: src/ptdt_div.sv
// ----------------------------------------------------------------------------
// ptdt_div
// Radix-2 restoring divider, one quotient bit per cycle, for the dead ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_div
  import ptdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [32:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [32:0]      dvd;
  logic [31:0]      dsr;
  logic [32:0]      rem_sh;
  logic             fits;
  logic [32:0]      rem_sub;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem, dvd[32]};
    fits    = (rem_sh >= {1'b0, dsr});
    rem_sub = rem_sh - {1'b0, dsr};
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder, dividend and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= dividend;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? rem_sub[31:0] : rem_sh[31:0];
      dvd      <= {dvd[31:0], 1'b0};
      quotient <= {quotient[31:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: src/ptdt_dpath.sv
// ----------------------------------------------------------------------------
// ptdt_dpath
// Datapath: input register, channel record memory, grading and unwrap logic,
// ratio divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_dpath
  import ptdt_pkg::*;
#(
  parameter int NUM_MODULES = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire in_t         in_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data
);

  // entry 0 is the trigger channel, entries 1..NUM_MODULES the modules
  localparam int DEPTH = NUM_MODULES + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int XW    = (IW > 5) ? IW : 5;

  logic [31:0] trig_limit;
  logic [23:0] mod_limit;

  in_t         in_q;
  chan_rec_t   mem [DEPTH];
  logic [DEPTH-1:0] vld;
  chan_rec_t   rd_q;
  logic        rd_vld;

  out_t        res_q;
  logic        use_div;
  out_t        out_load;

  logic [XW-1:0] mod_ext;
  logic [IW-1:0] idx;
  logic          mod_bad;

  chan_rec_t   rec;
  chan_rec_t   rec_next;
  logic        is_trig;
  logic [1:0]  bad;
  logic [15:0] mode_eff;
  logic        ped;
  logic [31:0] ts;
  logic [31:0] limit;
  logic        wrapped;
  logic [31:0] wait_v;
  logic [16:0] dd;
  logic        good;
  logic        tracked;
  logic [32:0] quo;
  logic        div_done;
  logic        drop;
  logic        need_div;
  logic        out_busy;
  out_t        res_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_limit <= '0;
      mod_limit  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIG_LIMIT: trig_limit <= cfg_data;
        CFG_MOD_LIMIT:  mod_limit  <= cfg_data[23:0];
        default:        trig_limit <= trig_limit;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_q <= in_data;
  end

  // channel index and drop check
  always_comb begin
    is_trig = in_q.req_type;
    mod_ext = XW'(in_q.module_number);
    idx     = is_trig ? '0 : mod_ext[IW-1:0];
    mod_bad = (in_q.module_number == 5'd0) ||
              ({27'd0, in_q.module_number} > 32'(NUM_MODULES));
  end

  assign drop = (in_q.packet_length < MIN_LEN) || (!is_trig && mod_bad);

  // record memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_q <= mem[idx];
    if (cmd.calc) mem[idx] <= rec_next;
  end

  // written-entry bits, an unwritten entry reads as the reset record
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.mem_rd) rd_vld <= vld[idx];
      if (cmd.calc) vld[idx] <= 1'b1;
    end
  end

  // grading, unwrap and record update
  always_comb begin
    rec      = rd_vld ? rd_q : REC_RESET;
    mode_eff = in_q.packet_mode;
    if (is_trig) begin
      ts    = in_q.time_stamp;
      limit = trig_limit;
      priority if (in_q.packet_length < TRIG_MIN_LEN) bad = BAD_SHORT;
      else if (!in_q.packet_valid) bad = BAD_INVALID;
      else if (!in_q.crc_ok) bad = BAD_CRC;
      else bad = BAD_GOOD;
      ped = (mode_eff == TRIG_PED_MODE);
    end else begin
      ts    = {8'd0, in_q.time_stamp[23:0]};
      limit = {8'd0, mod_limit};
      priority if (in_q.packet_length < MOD_MIN_LEN) begin
        bad = BAD_SHORT;
        if (in_q.packet_length < MOD_TINY_LEN) mode_eff = MOD_TINY_MODE;
      end else if ((in_q.packet_mode == MOD_RAW_MODE || in_q.packet_mode == MOD_PED_MODE)
                   && in_q.packet_length < MOD_PED_MIN_LEN) begin
        bad = BAD_SHORT;
      end else if (!in_q.packet_valid) begin
        bad = BAD_INVALID;
      end else if (!in_q.crc_ok) begin
        bad = BAD_CRC;
      end else begin
        bad = BAD_GOOD;
      end
      ped = (mode_eff == MOD_PED_MODE);
    end

    good    = (bad == BAD_GOOD);
    tracked = good && !rec.first;

    // backward step beyond the limit means the counter wrapped
    wrapped = ({1'b0, rec.stamp} > ({1'b0, ts} + {1'b0, limit}));
    wait_v  = ts - rec.stamp + ((wrapped && !is_trig) ? MOD_SPAN : 32'd0);

    // dead difference in 1..65536
    dd = (in_q.dead_count == rec.dead) ? DEAD_LAP
                                       : {1'b0, in_q.dead_count - rec.dead};

    rec_next     = rec;
    rec_next.bad = bad;
    if (good) begin
      rec_next.first = 1'b0;
      rec_next.stamp = ts;
      rec_next.dead  = in_q.dead_count;
      if (rec.first) begin
        rec_next.period = '0;
        rec_next.good   = 32'd1;
      end else begin
        rec_next.period = rec.period + {31'd0, wrapped};
        rec_next.good   = rec.good + 32'd1;
      end
    end

    res_next.trigger_flag    = is_trig;
    res_next.channel         = is_trig ? 5'd1 : in_q.module_number;
    res_next.pedestal_stream = ped;
    res_next.bad_code        = bad;
    res_next.prior_bad_code  = rec.bad;
    res_next.sequence_number = tracked ? rec.good : 32'd0;
    res_next.wrap_period     = tracked ? rec_next.period : 32'd0;
    res_next.tick_gap        = tracked ? wait_v : 32'd0;
    res_next.dead_frac       = (tracked && wait_v == 32'd0) ? '1 : 32'd0;
    res_next.mode_out        = mode_eff;
  end

  assign need_div = tracked && (wait_v != 32'd0);

  // result held until the ratio is ready
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      res_q   <= res_next;
      use_div <= need_div;
    end
  end

  // dead ratio divider
  ptdt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({dd, 16'd0}),
    .divisor  (wait_v),
    .done     (div_done),
    .quotient (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // held result with the saturated quotient merged in
  always_comb begin
    out_load = res_q;
    if (use_div) out_load.dead_frac = quo[32] ? '1 : quo[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data <= out_load;
  end

  assign out_busy = out_valid && out_stall;

  // status to the controller
  assign stat = '{drop: drop, need_div: need_div, div_done: div_done, out_busy: out_busy};

endmodule

`default_nettype wire

FILE: src/ptdt_ctrl.sv
// ----------------------------------------------------------------------------
// ptdt_ctrl
// Controller: sequences capture, record read, update, divide and output load.
// ----------------------------------------------------------------------------
`default_nettype none
`include "packet_time_and_deadtime_tracker_core_defines.svh"

module ptdt_ctrl
  import ptdt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        if (stat.drop) begin
          state_next = S_IDLE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checks
  `PTDT_ASSERT_NEXT(a_accept_reads, clk, rst, in_valid && !in_stall, state == S_READ, "accepted beat did not start a record read")
  `PTDT_ASSERT_NEXT(a_div_exit, clk, rst, state == S_DIV, state == S_DIV || state == S_DONE, "left divide wait to a wrong state")
  `PTDT_ASSERT_NOW(a_load_free, clk, rst, cmd.load_out, !stat.out_busy, "result loaded over a stalled beat")
  `PTDT_ASSERT_NOW(a_div_from_calc, clk, rst, cmd.div_start, cmd.calc, "divide started outside the update step")

endmodule

`default_nettype wire

FILE: src/packet_time_and_deadtime_tracker_core.sv
// ----------------------------------------------------------------------------
// packet_time_and_deadtime_tracker_core
// Grades science packets, keeps per-channel timestamp unwrap and packet
// numbering, and computes the Q16.16 dead ratio.
//
//   port group   direction  handshake           payload
//   in_*         input      in_valid/in_stall   in_data   (in_t)
//   out_*        output     out_valid/out_stall out_data  (out_t)
//   cfg_*        input      cfg_we              cfg_index, cfg_data
//
// A good packet that follows an earlier good one on its channel and has a
// nonzero wait also runs through the 33 steps of the radix-2 ratio divider;
// other graded packets skip it, and dropped packets go back to idle with no
// record read. Record reads and writes use one memory port per cycle.
// Reset (synchronous) empties the pipeline and marks every channel record
// unwritten at once, with no clearing pass. A stalled output beat holds only
// the final load; the next packet can already be accepted behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_time_and_deadtime_tracker_core
  import ptdt_pkg::*;
#(
  parameter int NUM_MODULES = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  ptdt_dpath #(
    .NUM_MODULES (NUM_MODULES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ptdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire
